/* src/pip_pkg.sv */
// shared constants, codes and types for the point in polygon test core
// no dependencies; used by point_in_polygon_test_core and pip_edge_unit
`default_nettype none

package pip_pkg;

  // defaults for the top-level parameters
  localparam int MAX_VERTICES_DEF = 16;
  localparam int COORD_BITS_DEF   = 12;

  // configuration register widths and reset values
  localparam int VCOUNT_W  = 5;
  localparam int RAY_END_W = 12;
  localparam logic [VCOUNT_W-1:0]  VCOUNT_RESET  = 5'd3;
  localparam logic [RAY_END_W-1:0] RAY_END_RESET = 12'd962;
  localparam int MIN_VERTICES = 3;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_VCOUNT  = 1'b0;
  localparam logic REG_RAY_END = 1'b1;

  // input item commands
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // verdict of one polygon edge against the ray
  typedef struct packed {
    logic valid;  // edge verdict present this cycle
    logic last;   // closing edge of the walk
    logic hit;    // edge intersects the ray segment
    logic col;    // point is collinear with the edge
    logic on;     // point lies on the edge
  } edge_res_t;

endpackage

`default_nettype wire

/* src/point_in_polygon_test_core.sv */
// point in polygon test core: registers, walk sequencer, result staging
// depends on pip_pkg, pip_vtx_mem and pip_edge_unit
//
//   port group   direction  handshake            payload
//   input item   in         in_valid_i/in_stall_o cmd_i, vertex_index_i, coord_x_i, coord_y_i
//   result item  out        out_valid_o/out_stall_i inside_res_o, on_edge_o
//   config       in/out     apb psel/penable     paddr, pwdata, prdata
//
// a vertex write gives no result.
// a query reads one vertex per cycle from the single read port of the vertex
// memory, one edge per cycle, and stages its result once the closing edge is
// judged (vertex_count clamped to 3..MAX_VERTICES).
// reset clears control state and the configuration registers; the vertex table is not cleared.
// a finished result waits in a staging register until the output register is
// free; the input stalls meanwhile, as it does during the walk, so the next
// transaction after a query is taken only after its result reaches the output register.
`default_nettype none

module point_in_polygon_test_core #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
  parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // input items
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          cmd_i,
  input  wire logic [3:0]                    vertex_index_i,
  input  wire logic [COORD_BITS-1:0]         coord_x_i,
  input  wire logic [COORD_BITS-1:0]         coord_y_i,
  // result items
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               inside_res_o,
  output logic                               on_edge_o,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [pip_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [pip_pkg::PDATA_W-1:0]   pwdata,
  output logic      [pip_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);

  localparam int CB    = COORD_BITS;
  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CW    = (IDX_W + 1 > pip_pkg::VCOUNT_W) ? IDX_W + 1 : pip_pkg::VCOUNT_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // configuration registers
  logic [pip_pkg::VCOUNT_W-1:0]  vcount_q;
  logic [pip_pkg::RAY_END_W-1:0] ray_end_q;
  logic                          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q  <= pip_pkg::VCOUNT_RESET;
      ray_end_q <= pip_pkg::RAY_END_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        pip_pkg::REG_VCOUNT:  vcount_q  <= pwdata[pip_pkg::VCOUNT_W-1:0];
        pip_pkg::REG_RAY_END: ray_end_q <= pwdata[pip_pkg::RAY_END_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      pip_pkg::REG_VCOUNT:  prdata = pip_pkg::PDATA_W'(vcount_q);
      pip_pkg::REG_RAY_END: prdata = pip_pkg::PDATA_W'(ray_end_q);
      default:              prdata = '0;
    endcase
  end

  // input transaction decode
  logic [1:0] state_q, state_d;
  logic       pend_q;
  logic       in_acc, vtx_we, query_go;
  logic [CW-1:0] idx_w;

  assign in_stall_o = (state_q != ST_IDLE) || pend_q;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign idx_w      = CW'(vertex_index_i);
  assign vtx_we     = in_acc && (cmd_i == pip_pkg::CMD_WRITE) &&
                      (idx_w < CW'(MAX_VERTICES));
  assign query_go   = in_acc && (cmd_i == pip_pkg::CMD_QUERY);

  // clamp the vertex count to the supported range
  logic [CW-1:0]    vc_w, n_eff, n_m1;
  logic [IDX_W-1:0] n_last_q;

  always_comb begin
    vc_w = CW'(vcount_q);
    if (vc_w < CW'(pip_pkg::MIN_VERTICES)) begin
      n_eff = CW'(pip_pkg::MIN_VERTICES);
    end else if (vc_w > CW'(MAX_VERTICES)) begin
      n_eff = CW'(MAX_VERTICES);
    end else begin
      n_eff = vc_w;
    end
    n_m1 = n_eff - 1'b1;
  end

  // vertex memory
  logic [IDX_W-1:0]  rd_cnt_q;
  logic [2*CB-1:0]   rdata;
  logic              rd_en;

  assign rd_en = (state_q == ST_READ);

  pip_vtx_mem #(
    .DEPTH (MAX_VERTICES),
    .AW    (IDX_W),
    .DW    (2 * CB)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (vtx_we),
    .waddr_i (idx_w[IDX_W-1:0]),
    .wdata_i ({coord_y_i, coord_x_i}),
    .re_i    (rd_en),
    .raddr_i (rd_cnt_q),
    .rdata_o (rdata)
  );

  // walk sequencer
  logic edge_done;
  pip_pkg::edge_res_t eres;

  assign edge_done = eres.valid && eres.last;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (query_go) state_d = ST_READ;
      ST_READ:  if (rd_cnt_q == n_last_q) state_d = ST_DRAIN;
      ST_DRAIN: if (edge_done) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  logic rd_valid_q, rd_first_q, rd_last_q, close_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rd_cnt_q   <= '0;
      n_last_q   <= '0;
      rd_valid_q <= 1'b0;
      rd_first_q <= 1'b0;
      rd_last_q  <= 1'b0;
      close_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      rd_valid_q <= rd_en;
      rd_first_q <= rd_en && (rd_cnt_q == '0);
      rd_last_q  <= rd_en && (rd_cnt_q == n_last_q);
      close_q    <= rd_valid_q && rd_last_q;
      if (query_go) begin
        rd_cnt_q <= '0;
        n_last_q <= n_m1[IDX_W-1:0];
      end else if (rd_en) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end
    end
  end

  // query point and vertex history
  logic [CB-1:0] px_q, py_q, ex_q, v0x_q, v0y_q, prvx_q, prvy_q;
  logic [CB-1:0] cur_x, cur_y;

  assign cur_x = rdata[CB-1:0];
  assign cur_y = rdata[2*CB-1:CB];

  always_ff @(posedge clk_i) begin
    if (query_go) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
      ex_q <= CB'(ray_end_q);
    end
    if (rd_valid_q) begin
      prvx_q <= cur_x;
      prvy_q <= cur_y;
      if (rd_first_q) begin
        v0x_q <= cur_x;
        v0y_q <= cur_y;
      end
    end
  end

  // edge launch: previous vertex to current, closing edge back to vertex zero
  logic          e_valid;
  logic [CB-1:0] e_bx, e_by;

  assign e_valid = (rd_valid_q && !rd_first_q) || close_q;
  assign e_bx    = close_q ? v0x_q : cur_x;
  assign e_by    = close_q ? v0y_q : cur_y;

  pip_edge_unit #(
    .CB (CB)
  ) u_edge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (e_valid),
    .last_i  (close_q),
    .ax_i    (prvx_q),
    .ay_i    (prvy_q),
    .bx_i    (e_bx),
    .by_i    (e_by),
    .px_i    (px_q),
    .py_i    (py_q),
    .ex_i    (ex_q),
    .res_o   (eres)
  );

  // crossing parity and first collinear verdict
  logic decided_q, dec_on_q, parity_q;
  logic decided_d, dec_on_d, parity_d;

  always_comb begin
    decided_d = decided_q;
    dec_on_d  = dec_on_q;
    parity_d  = parity_q;
    if (eres.valid && !decided_q && eres.hit) begin
      if (eres.col) begin
        decided_d = 1'b1;
        dec_on_d  = eres.on;
      end else begin
        parity_d = !parity_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      decided_q <= 1'b0;
      dec_on_q  <= 1'b0;
      parity_q  <= 1'b0;
    end else if (query_go) begin
      decided_q <= 1'b0;
      dec_on_q  <= 1'b0;
      parity_q  <= 1'b0;
    end else begin
      decided_q <= decided_d;
      dec_on_q  <= dec_on_d;
      parity_q  <= parity_d;
    end
  end

  // result staging and output register
  logic pend_inside_q, pend_edge_q;
  logic out_valid_q, out_inside_q, out_edge_q;
  logic out_load;

  assign out_load = pend_q && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (edge_done) begin
        pend_q <= 1'b1;
      end else if (out_load) begin
        pend_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_done) begin
      pend_inside_q <= decided_d ? dec_on_d : parity_d;
      pend_edge_q   <= decided_d && dec_on_d;
    end
    if (out_load) begin
      out_inside_q <= pend_inside_q;
      out_edge_q   <= pend_edge_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = out_inside_q;
  assign on_edge_o    = out_edge_q;

endmodule

`default_nettype wire

/* src/pip_vtx_mem.sv */
// vertex table: single write port, single registered read port
// no dependencies
`default_nettype none

module pip_vtx_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 24
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/pip_edge_unit.sv */
// two-stage edge test: orientation products, then sign and bounds checks
// depends on pip_pkg for the edge verdict type
`default_nettype none

module pip_edge_unit #(
  parameter int CB = pip_pkg::COORD_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  input  wire logic          last_i,
  input  wire logic [CB-1:0] ax_i,
  input  wire logic [CB-1:0] ay_i,
  input  wire logic [CB-1:0] bx_i,
  input  wire logic [CB-1:0] by_i,
  input  wire logic [CB-1:0] px_i,
  input  wire logic [CB-1:0] py_i,
  input  wire logic [CB-1:0] ex_i,
  output pip_pkg::edge_res_t res_o
);

  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int VW = PW + 1;

  function automatic logic in_span(logic [CB-1:0] a, logic [CB-1:0] b, logic [CB-1:0] c);
    logic [CB-1:0] lo;
    logic [CB-1:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    return (c >= lo) && (c <= hi);
  endfunction

  // stage one: coordinate differences and the three products
  logic signed [DW-1:0] d_bay, d_pxbx, d_exbx, d_pyby, d_bxax;
  logic signed [PW-1:0] m1_d, m2_d, m3_d;

  assign d_bay  = {1'b0, by_i} - {1'b0, ay_i};
  assign d_pxbx = {1'b0, px_i} - {1'b0, bx_i};
  assign d_exbx = {1'b0, ex_i} - {1'b0, bx_i};
  assign d_pyby = {1'b0, py_i} - {1'b0, by_i};
  assign d_bxax = {1'b0, bx_i} - {1'b0, ax_i};
  assign m1_d   = d_bay * d_pxbx;
  assign m2_d   = d_bay * d_exbx;
  assign m3_d   = d_pyby * d_bxax;

  logic                 s1_valid_q, s1_last_q;
  logic signed [PW-1:0] m1_q, m2_q, m3_q;
  logic [CB-1:0]        ax_q, ay_q, bx_q, by_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_last_q  <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s1_last_q  <= last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q <= m1_d;
    m2_q <= m2_d;
    m3_q <= m3_d;
    ax_q <= ax_i;
    ay_q <= ay_i;
    bx_q <= bx_i;
    by_q <= by_i;
  end

  // stage two: orientations of the point and the ray end against the edge
  logic [VW-1:0] v1, v2;
  logic z1, n1, z2, n2;

  assign v1 = {m1_q[PW-1], m1_q} - {m3_q[PW-1], m3_q};
  assign v2 = {m2_q[PW-1], m2_q} - {m3_q[PW-1], m3_q};
  assign z1 = (v1 == '0);
  assign n1 = v1[VW-1];
  assign z2 = (v2 == '0);
  assign n2 = v2[VW-1];

  // orientations of the edge ends against the horizontal ray, from signs only
  logic za, na, zb, nb, ze, ne, z3, n3, z4, n4;

  assign za = (ay_q == py_i);
  assign na = (ay_q < py_i);
  assign zb = (by_q == py_i);
  assign nb = (by_q < py_i);
  assign ze = (ex_i == px_i);
  assign ne = (ex_i < px_i);
  assign z3 = za | ze;
  assign n3 = !z3 && (na == ne);
  assign z4 = zb | ze;
  assign n4 = !z4 && (nb == ne);

  logic diff12, diff34;
  assign diff12 = !((z1 == z2) && (z1 || (n1 == n2)));
  assign diff34 = !((z3 == z4) && (z3 || (n3 == n4)));

  // collinear special cases
  logic on_abp, on_abe, on_pea, on_peb;
  assign on_abp = in_span(ax_q, bx_q, px_i) && in_span(ay_q, by_q, py_i);
  assign on_abe = in_span(ax_q, bx_q, ex_i) && in_span(ay_q, by_q, py_i);
  assign on_pea = za && in_span(px_i, ex_i, ax_q);
  assign on_peb = zb && in_span(px_i, ex_i, bx_q);

  pip_pkg::edge_res_t res_d, res_q;

  always_comb begin
    res_d.valid = s1_valid_q;
    res_d.last  = s1_last_q;
    res_d.hit   = (diff12 && diff34) || (z1 && on_abp) || (z2 && on_abe) ||
                  (z3 && on_pea) || (z4 && on_peb);
    res_d.col   = z1;
    res_d.on    = on_abp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

/* dv/point_in_polygon_test_core_test.sv */
// testbench for point_in_polygon_test_core: vertex loads, point queries, apb registers
// depends on pip_pkg and the point_in_polygon_test_core rtl; a class predicts each verdict
`timescale 1ns / 1ps

module point_in_polygon_test_core_test;

  localparam int CW   = pip_pkg::COORD_BITS_DEF;
  localparam int MAXV = pip_pkg::MAX_VERTICES_DEF;
  localparam logic [CW-1:0] COORD_TOP = {CW{1'b1}};
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 55;
  localparam int SETTLE_CYCLES = MAXV + 14;

  typedef struct packed {
    logic in_poly;
    logic on_edge;
  } verdict_t;

  typedef enum logic [1:0] {ORI_COLLINEAR, ORI_CW, ORI_CCW} turn_t;

  // predicted verdicts of accepted queries, checked in arrival order
  class pip_verdict_board;
    logic [CW-1:0] vx [MAXV];
    logic [CW-1:0] vy [MAXV];
    logic [pip_pkg::VCOUNT_W-1:0]  vcount;
    logic [pip_pkg::RAY_END_W-1:0] ray_end;
    verdict_t pending_verdicts [$];
    int mismatches;
    int writes_seen;
    int queries_seen;
    int edge_hits;
    int inside_hits;

    function new();
      vcount = pip_pkg::VCOUNT_RESET;
      ray_end = pip_pkg::RAY_END_RESET;
      mismatches = 0;
      writes_seen = 0;
      queries_seen = 0;
      edge_hits = 0;
      inside_hits = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    function void set_config(logic sel, logic [pip_pkg::PDATA_W-1:0] value);
      if (sel == pip_pkg::REG_VCOUNT) vcount = value[pip_pkg::VCOUNT_W-1:0];
      else ray_end = value[pip_pkg::RAY_END_W-1:0];
    endfunction

    // vertex count as the walk uses it
    function int active_vertices();
      int n;
      n = int'(vcount);
      if (n < pip_pkg::MIN_VERTICES) n = pip_pkg::MIN_VERTICES;
      if (n > MAXV) n = MAXV;
      return n;
    endfunction

    function int outstanding();
      return pending_verdicts.size();
    endfunction

    function turn_t turn(input longint ax, ay, bx, by, cx, cy);
      longint v;
      v = (by - ay) * (cx - bx) - (cy - by) * (bx - ax);
      if (v == 0) return ORI_COLLINEAR;
      return (v > 0) ? ORI_CW : ORI_CCW;
    endfunction

    function bit in_span(input longint a, b, c);
      longint lo;
      longint hi;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      return (c >= lo) && (c <= hi);
    endfunction

    // bounding test on both axes
    function bit on_seg(input longint ax, ay, bx, by, cx, cy);
      return in_span(ax, bx, cx) && in_span(ay, by, cy);
    endfunction

    function bit segs_meet(input longint ax, ay, bx, by, cx, cy, dx, dy);
      turn_t o1, o2, o3, o4;
      o1 = turn(ax, ay, bx, by, cx, cy);
      o2 = turn(ax, ay, bx, by, dx, dy);
      o3 = turn(cx, cy, dx, dy, ax, ay);
      o4 = turn(cx, cy, dx, dy, bx, by);
      if (o1 != o2 && o3 != o4) return 1'b1;
      if (o1 == ORI_COLLINEAR && on_seg(ax, ay, bx, by, cx, cy)) return 1'b1;
      if (o2 == ORI_COLLINEAR && on_seg(ax, ay, bx, by, dx, dy)) return 1'b1;
      if (o3 == ORI_COLLINEAR && on_seg(cx, cy, dx, dy, ax, ay)) return 1'b1;
      if (o4 == ORI_COLLINEAR && on_seg(cx, cy, dx, dy, bx, by)) return 1'b1;
      return 1'b0;
    endfunction

    // walk every closed edge against the ray from the point to ray_end
    function verdict_t ray_cast_verdict(logic [CW-1:0] px, logic [CW-1:0] py);
      verdict_t v;
      int n;
      int j;
      int crossings;
      longint ax, ay, bx, by;
      n = active_vertices();
      crossings = 0;
      for (int i = 0; i < n; i++) begin
        j = (i + 1 == n) ? 0 : i + 1;
        ax = vx[i];
        ay = vy[i];
        bx = vx[j];
        by = vy[j];
        if (segs_meet(ax, ay, bx, by, px, py, ray_end, py)) begin
          // collinear edge decides at once
          if (turn(ax, ay, bx, by, px, py) == ORI_COLLINEAR) begin
            v.on_edge = on_seg(ax, ay, bx, by, px, py);
            v.in_poly = v.on_edge;
            return v;
          end
          crossings++;
        end
      end
      v.in_poly = crossings[0];
      v.on_edge = 1'b0;
      return v;
    endfunction

    function void note_item(logic cmd, logic [3:0] idx, logic [CW-1:0] x, logic [CW-1:0] y);
      verdict_t v;
      if (cmd == pip_pkg::CMD_WRITE) begin
        if (int'(idx) < MAXV) begin
          vx[idx] = x;
          vy[idx] = y;
        end
        writes_seen++;
      end else begin
        v = ray_cast_verdict(x, y);
        pending_verdicts = {pending_verdicts, v};
        queries_seen++;
        if (v.on_edge) edge_hits++;
        if (v.in_poly) inside_hits++;
      end
    endfunction

    function void check_verdict(logic in_poly, logic on_edge);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        flag($sformatf("result with no query waiting: inside %b on_edge %b", in_poly, on_edge));
        return;
      end
      want = pending_verdicts.pop_front();
      if (in_poly !== want.in_poly)
        flag($sformatf("inside_res expected %b got %b", want.in_poly, in_poly));
      if (on_edge !== want.on_edge)
        flag($sformatf("on_edge expected %b got %b", want.on_edge, on_edge));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_stall_o;
  logic in_cmd;
  logic [3:0] in_index;
  logic [CW-1:0] in_x;
  logic [CW-1:0] in_y;
  logic out_valid_o;
  logic out_stall;
  logic inside_res_o;
  logic on_edge_o;
  logic psel;
  logic penable;
  logic pwrite;
  logic [pip_pkg::PADDR_W-1:0] paddr;
  logic [pip_pkg::PDATA_W-1:0] pwdata;
  logic [pip_pkg::PDATA_W-1:0] prdata;
  logic pready;

  pip_verdict_board board = new();

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int items_sent = 0;
  int settings_used = 0;

  // stimulus-side copy of what has been loaded, kept apart from the predictor
  logic [CW-1:0] stim_x [MAXV];
  logic [CW-1:0] stim_y [MAXV];
  bit [MAXV-1:0] loaded = '0;
  int poly_base = 0;
  int poly_span = 4095;

  point_in_polygon_test_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .cmd_i          (in_cmd),
    .vertex_index_i (in_index),
    .coord_x_i      (in_x),
    .coord_y_i      (in_y),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .inside_res_o   (inside_res_o),
    .on_edge_o      (on_edge_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #1000000;
    $display("** point_in_polygon_test_core: FAILED **");
    $finish;
  end

  // receiver: random stall, or a long hold-off when requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // transaction monitor on both channels
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_valid === 1'b1 && in_stall_o === 1'b0)
        board.note_item(in_cmd, in_index, in_x, in_y);
      if (out_valid_o === 1'b1 && out_stall === 1'b0)
        board.check_verdict(inside_res_o, on_edge_o);
    end
  end

  task automatic send_item(input logic cmd, input logic [3:0] idx,
                           input logic [CW-1:0] x, input logic [CW-1:0] y);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_index <= idx;
    in_x <= x;
    in_y <= y;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (cmd == pip_pkg::CMD_WRITE) begin
      stim_x[idx] = x;
      stim_y[idx] = y;
      loaded[idx] = 1'b1;
    end
    items_sent++;
  endtask

  task automatic rest_sender();
    @(negedge clk_i);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (board.outstanding() != 0) @(posedge clk_i);
  endtask

  // apb write followed by a read-back of the same register
  task automatic set_register(input logic sel, input logic [pip_pkg::PDATA_W-1:0] value);
    logic [pip_pkg::PADDR_W-1:0] addr;
    logic [pip_pkg::PDATA_W-1:0] want;
    logic [pip_pkg::PDATA_W-1:0] got;
    addr = {sel, 2'b00};
    want = (sel == pip_pkg::REG_VCOUNT) ? (value & ((1 << pip_pkg::VCOUNT_W) - 1))
                                        : (value & ((1 << pip_pkg::RAY_END_W) - 1));
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    board.set_config(sel, value);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    got = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== want)
      board.flag($sformatf("register at %0d read back %0h, expected %0h", addr, got, want));
  endtask

  // wait for the block to go quiet, then change the settings
  task automatic reconfigure(input int vc, input int re);
    rest_sender();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    set_register(pip_pkg::REG_VCOUNT, vc);
    set_register(pip_pkg::REG_RAY_END, re);
    settings_used++;
  endtask

  function automatic logic [CW-1:0] rand_coord(int base, int span);
    if (span >= 4095 && $urandom_range(7) == 0)
      return $urandom_range(1) ? COORD_TOP : '0;
    return CW'(base + $urandom_range(0, span));
  endfunction

  function automatic bit stim_ready();
    for (int i = 0; i < board.active_vertices(); i++)
      if (!loaded[i]) return 1'b0;
    return 1'b1;
  endfunction

  // query point aimed at vertices, edges and their extensions
  task automatic send_query();
    int n, i, j, tx, ty;
    logic [CW-1:0] qx, qy;
    n = board.active_vertices();
    i = $urandom_range(0, n - 1);
    j = (i + 1 == n) ? 0 : i + 1;
    qx = rand_coord(poly_base, poly_span);
    qy = rand_coord(poly_base, poly_span);
    case ($urandom_range(0, 5))
      0: begin
        qx = stim_x[i];
        qy = stim_y[i];
      end
      1: begin
        qx = CW'((int'(stim_x[i]) + int'(stim_x[j])) / 2);
        qy = CW'((int'(stim_y[i]) + int'(stim_y[j])) / 2);
      end
      2: qy = stim_y[i];
      3: ;
      4: begin
        qx = rand_coord(0, 4095);
        qy = rand_coord(0, 4095);
      end
      default: begin
        // point on the line of an edge, past its end
        tx = 2 * int'(stim_x[j]) - int'(stim_x[i]);
        ty = 2 * int'(stim_y[j]) - int'(stim_y[i]);
        if (tx < 0 || tx > 4095 || ty < 0 || ty > 4095) begin
          tx = 2 * int'(stim_x[i]) - int'(stim_x[j]);
          ty = 2 * int'(stim_y[i]) - int'(stim_y[j]);
        end
        if (tx >= 0 && tx <= 4095 && ty >= 0 && ty <= 4095) begin
          qx = CW'(tx);
          qy = CW'(ty);
        end
      end
    endcase
    send_item(pip_pkg::CMD_QUERY, 4'($urandom_range(15)), qx, qy);
  endtask

  task automatic load_polygon();
    int n;
    int spans [4];
    spans = '{12, 40, 600, 4095};
    n = board.active_vertices();
    poly_span = spans[$urandom_range(0, 3)];
    poly_base = $urandom_range(0, 4095 - poly_span);
    for (int i = 0; i < n; i++)
      send_item(pip_pkg::CMD_WRITE, 4'(i), rand_coord(poly_base, poly_span),
                rand_coord(poly_base, poly_span));
    // a slot past the active count must not disturb the walk
    if (n < MAXV && $urandom_range(3) == 0)
      send_item(pip_pkg::CMD_WRITE, 4'($urandom_range(n, MAXV - 1)),
                rand_coord(0, 4095), rand_coord(0, 4095));
  endtask

  task automatic run_phase(input int budget);
    int start;
    start = items_sent;
    while (items_sent - start < budget) begin
      if ($urandom_range(3) != 0) begin
        load_polygon();
        repeat ($urandom_range(2, 8)) send_query();
      end else begin
        // noise: stray vertex writes and queries against whatever is loaded
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(1) == 0 || !stim_ready())
            send_item(pip_pkg::CMD_WRITE, 4'($urandom_range(15)),
                      rand_coord(0, 4095), rand_coord(0, 4095));
          else
            send_item(pip_pkg::CMD_QUERY, 4'($urandom_range(15)),
                      rand_coord(0, 4095), rand_coord(0, 4095));
        end
      end
    end
  endtask

  initial begin
    int vc_list [PHASES];
    int mode;
    int re;
    vc_list = '{3, 16, 0, 31, 7, 2, 17, 12, 1, 5, 16, 9};
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_cmd = pip_pkg::CMD_WRITE;
    in_index = '0;
    in_x = '0;
    in_y = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: triangle under reset settings
    send_item(pip_pkg::CMD_WRITE, 4'd0, 12'd100, 12'd100);
    send_item(pip_pkg::CMD_WRITE, 4'd1, 12'd900, 12'd100);
    send_item(pip_pkg::CMD_WRITE, 4'd2, 12'd500, 12'd800);
    send_item(pip_pkg::CMD_QUERY, 4'd0, 12'd500, 12'd300);    // inside
    send_item(pip_pkg::CMD_QUERY, 4'd15, 12'd50, 12'd50);     // outside
    send_item(pip_pkg::CMD_QUERY, 4'd0, 12'd500, 12'd100);    // on the bottom edge
    send_item(pip_pkg::CMD_QUERY, 4'd0, 12'd100, 12'd100);    // on a vertex
    send_item(pip_pkg::CMD_QUERY, 4'd0, 12'd300, 12'd450);    // on a slanted edge
    send_item(pip_pkg::CMD_QUERY, 4'd0, 12'd50, 12'd100);     // collinear but off the edge
    send_item(pip_pkg::CMD_QUERY, 4'd0, 12'd1000, 12'd300);   // ray runs leftward
    send_item(pip_pkg::CMD_QUERY, 4'd0, 12'd300, 12'd800);    // ray through the apex
    send_item(pip_pkg::CMD_QUERY, 4'd0, 12'd0, 12'd0);
    send_item(pip_pkg::CMD_QUERY, 4'd15, COORD_TOP, COORD_TOP);
    send_item(pip_pkg::CMD_WRITE, 4'd15, COORD_TOP, COORD_TOP);
    send_item(pip_pkg::CMD_WRITE, 4'd3, COORD_TOP, 12'd0);
    // count below the floor, ray toward x zero
    reconfigure(0, 0);
    send_item(pip_pkg::CMD_QUERY, 4'd0, 12'd500, 12'd300);
    send_item(pip_pkg::CMD_QUERY, 4'd0, 12'd950, 12'd100);
    // four vertices, ray to the far right
    reconfigure(4, 4095);
    send_item(pip_pkg::CMD_QUERY, 4'd0, 12'd2000, 12'd300);
    send_item(pip_pkg::CMD_QUERY, 4'd0, COORD_TOP, 12'd0);

    // long hold-off on the result side while queries keep coming
    rest_sender();
    drain();
    hold_left = 300;
    poly_base = 0;
    poly_span = 4095;
    repeat (20) send_query();
    rest_sender();
    drain();

    // random phases over idle patterns and register settings
    for (int p = 0; p < PHASES; p++) begin
      mode = p % 4;
      case (p % 3)
        0: re = $urandom_range(1) ? 4095 : 0;
        1: re = 962;
        default: re = $urandom_range(0, 4095);
      endcase
      reconfigure(vc_list[p], re);
      send_idle_pct = (mode == 1) ? 51 : (mode == 3) ? 18 : 0;
      stall_pct = (mode == 2) ? 51 : (mode == 3) ? 18 : 0;
      run_phase(PHASE_ITEMS);
    end

    rest_sender();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.outstanding() != 0)
      board.flag($sformatf("%0d results never arrived", board.outstanding()));
    $display("covered %0d vertex writes and %0d queries (%0d on an edge, %0d inside)",
             board.writes_seen, board.queries_seen, board.edge_hits, board.inside_hits);
    $display("over %0d register settings; %0d mismatches", settings_used, board.mismatches);
    if (board.mismatches == 0) begin
      $display("** point_in_polygon_test_core: PASSED **");
    end else begin
      $display("** point_in_polygon_test_core: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
src/pip_pkg.sv
src/pip_vtx_mem.sv
src/pip_edge_unit.sv
src/point_in_polygon_test_core.sv
dv/point_in_polygon_test_core_test.sv
